/* rtl/core/nssf_pkg.sv */
// ----------------------------------------------------------------------------
// nssf_pkg
// Shared types and constants for the nearest-seek-first scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package nssf_pkg;

  localparam int MaxRequests = 64;
  localparam int IdxW        = $clog2(MaxRequests);
  localparam int CntW        = $clog2(MaxRequests + 1);
  localparam int TrackW      = 16;
  localparam int TotalW      = 22;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT
  } state_e;

  // Result word handed from the engine to the output register.
  typedef struct packed {
    logic              valid;
    logic [TrackW-1:0] track;
    logic [TrackW-1:0] seek;
    logic [TotalW-1:0] total;
    logic              last;
  } res_t;

endpackage

`default_nettype wire

/* rtl/core/nssf_engine.sv */
// ----------------------------------------------------------------------------
// nssf_engine
// Request store, served flags and the nearest-track scan sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module nssf_engine (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic [nssf_pkg::TrackW-1:0]  start_head_i,
  input  wire logic                         req_valid_i,
  output logic                              req_ready_o,
  input  wire logic [nssf_pkg::TrackW-1:0]  req_track_i,
  input  wire logic                         req_last_i,
  output nssf_pkg::res_t                    res_o,
  input  wire logic                         res_ready_i
);

  nssf_pkg::state_e state_q, state_d;

  logic [nssf_pkg::CntW-1:0]   count_q, count_d;
  logic [nssf_pkg::IdxW-1:0]   j_q, j_d;
  logic [nssf_pkg::IdxW-1:0]   k_q, k_d;
  logic                        pv_q, pv_d;
  logic [nssf_pkg::IdxW-1:0]   pidx_q, pidx_d;
  logic                        found_q, found_d;
  logic [nssf_pkg::TrackW-1:0] best_dist_q, best_dist_d;
  logic [nssf_pkg::IdxW-1:0]   best_idx_q, best_idx_d;
  logic [nssf_pkg::TrackW-1:0] best_trk_q, best_trk_d;
  logic [nssf_pkg::TrackW-1:0] head_q, head_d;
  logic [nssf_pkg::TotalW-1:0] total_q, total_d;
  logic [nssf_pkg::MaxRequests-1:0] served_q, served_d;

  // request store: one write port, one registered read port
  logic [nssf_pkg::TrackW-1:0] mem [nssf_pkg::MaxRequests];
  logic                        mem_we;
  logic [nssf_pkg::IdxW-1:0]   mem_waddr;
  logic [nssf_pkg::IdxW-1:0]   mem_raddr;
  logic [nssf_pkg::TrackW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= req_track_i;
    end
    rd_data_q <= mem[mem_raddr];
  end

  logic [nssf_pkg::TrackW-1:0] gap;
  logic [nssf_pkg::TotalW-1:0] total_new;
  logic                        last_res;
  logic                        scan_end;

  assign gap = (rd_data_q >= head_q) ? (rd_data_q - head_q) : (head_q - rd_data_q);
  assign total_new = total_q + nssf_pkg::TotalW'(best_dist_q);
  assign last_res  = ({1'b0, k_q} + nssf_pkg::CntW'(1)) == count_q;
  assign scan_end  = ({1'b0, j_q} + nssf_pkg::CntW'(1)) == count_q;

  assign mem_waddr = count_q[nssf_pkg::IdxW-1:0];
  assign mem_raddr = j_q;

  assign req_ready_o = (state_q == nssf_pkg::ST_LOAD);

  always_comb begin
    res_o.valid = (state_q == nssf_pkg::ST_EMIT);
    res_o.track = best_trk_q;
    res_o.seek  = best_dist_q;
    res_o.total = total_new;
    res_o.last  = last_res;
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    j_d         = j_q;
    k_d         = k_q;
    pv_d        = 1'b0;
    pidx_d      = pidx_q;
    found_d     = found_q;
    best_dist_d = best_dist_q;
    best_idx_d  = best_idx_q;
    best_trk_d  = best_trk_q;
    head_d      = head_q;
    total_d     = total_q;
    served_d    = served_q;
    mem_we      = 1'b0;

    // compare the word read last cycle against the best so far
    if (pv_q && !served_q[pidx_q] && (!found_q || gap < best_dist_q)) begin
      found_d     = 1'b1;
      best_dist_d = gap;
      best_idx_d  = pidx_q;
      best_trk_d  = rd_data_q;
    end

    case (state_q)
      nssf_pkg::ST_LOAD: begin
        if (req_valid_i) begin
          if (count_q < nssf_pkg::CntW'(nssf_pkg::MaxRequests)) begin
            mem_we  = 1'b1;
            count_d = count_q + nssf_pkg::CntW'(1);
          end
          if (req_last_i) begin
            head_d  = start_head_i;
            total_d = '0;
            j_d     = '0;
            k_d     = '0;
            found_d = 1'b0;
            state_d = nssf_pkg::ST_SCAN;
          end
        end
      end
      nssf_pkg::ST_SCAN: begin
        pv_d   = 1'b1;
        pidx_d = j_q;
        j_d    = j_q + nssf_pkg::IdxW'(1);
        if (scan_end) begin
          state_d = nssf_pkg::ST_DRAIN;
        end
      end
      nssf_pkg::ST_DRAIN: begin
        state_d = nssf_pkg::ST_EMIT;
      end
      nssf_pkg::ST_EMIT: begin
        if (res_ready_i) begin
          served_d[best_idx_q] = 1'b1;
          head_d  = best_trk_q;
          total_d = total_new;
          k_d     = k_q + nssf_pkg::IdxW'(1);
          j_d     = '0;
          found_d = 1'b0;
          if (last_res) begin
            count_d  = '0;
            served_d = '0;
            state_d  = nssf_pkg::ST_LOAD;
          end else begin
            state_d = nssf_pkg::ST_SCAN;
          end
        end
      end
      default: begin
        state_d = nssf_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= nssf_pkg::ST_LOAD;
      count_q  <= '0;
      j_q      <= '0;
      k_q      <= '0;
      pv_q     <= 1'b0;
      found_q  <= 1'b0;
      head_q   <= '0;
      total_q  <= '0;
      served_q <= '0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      j_q      <= j_d;
      k_q      <= k_d;
      pv_q     <= pv_d;
      found_q  <= found_d;
      head_q   <= head_d;
      total_q  <= total_d;
      served_q <= served_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q      <= pidx_d;
    best_dist_q <= best_dist_d;
    best_idx_q  <= best_idx_d;
    best_trk_q  <= best_trk_d;
  end

endmodule

`default_nettype wire

/* rtl/core/nearest_seek_first_scheduler_top.sv */
// ----------------------------------------------------------------------------
// nearest_seek_first_scheduler_top
// Batch disk-request scheduler: serves the nearest unserved track first.
// ----------------------------------------------------------------------------
//
//   channel  | handshake              | word
//   ---------+------------------------+------------------------------------------
//   cfg      | cfg_valid_i/cfg_ready_o | cfg_data_i = start head track
//   request  | req_valid_i/req_ready_o | req_track_i, req_last_i
//   result   | res_valid_o/res_ready_i | served_track_o, seek_distance_o,
//            |                         | total_seek_o, last_served_o
//
// Requests load at one word per cycle into a 64-entry store. The word with
// req_last_i closes the batch; requests beyond 64 are dropped.
// Service of a batch of N requests: each result takes one full read sweep
// of the store through its single read port, a drain state for the
// registered read, and an emit state that waits for the output register.
// Request input is held off from the last word until the final result has
// left the engine; the output register lets that result wait for the sink
// while the next batch loads.
// Reset clears the batch count, served flags, head and total at once.
// Ties in distance go to the earlier loaded request (strict-less compare).
//
`default_nettype none

module nearest_seek_first_scheduler_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [15:0] cfg_data_i,
  // request channel
  input  wire logic        req_valid_i,
  output logic             req_ready_o,
  input  wire logic [15:0] req_track_i,
  input  wire logic        req_last_i,
  // result channel
  output logic             res_valid_o,
  input  wire logic        res_ready_i,
  output logic [15:0]      served_track_o,
  output logic [15:0]      seek_distance_o,
  output logic [21:0]      total_seek_o,
  output logic             last_served_o
);

  logic [nssf_pkg::TrackW-1:0] start_head_q;
  nssf_pkg::res_t              eng_res;
  logic                        slot_free;

  // start head register, always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_head_q <= '0;
    end else if (cfg_valid_i) begin
      start_head_q <= cfg_data_i;
    end
  end

  nssf_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_head_i (start_head_q),
    .req_valid_i  (req_valid_i),
    .req_ready_o  (req_ready_o),
    .req_track_i  (req_track_i),
    .req_last_i   (req_last_i),
    .res_o        (eng_res),
    .res_ready_i  (slot_free)
  );

  // output register: takes a new word when empty or being drained
  logic                        out_valid_q;
  logic [nssf_pkg::TrackW-1:0] out_track_q;
  logic [nssf_pkg::TrackW-1:0] out_dist_q;
  logic [nssf_pkg::TotalW-1:0] out_total_q;
  logic                        out_last_q;

  assign slot_free = !out_valid_q || res_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (slot_free) begin
      out_valid_q <= eng_res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_free && eng_res.valid) begin
      out_track_q <= eng_res.track;
      out_dist_q  <= eng_res.seek;
      out_total_q <= eng_res.total;
      out_last_q  <= eng_res.last;
    end
  end

  assign res_valid_o     = out_valid_q;
  assign served_track_o  = out_track_q;
  assign seek_distance_o = out_dist_q;
  assign total_seek_o    = out_total_q;
  assign last_served_o   = out_last_q;

endmodule

`default_nettype wire

/* rtl/core/nssf_checker.sv */
// ----------------------------------------------------------------------------
// nssf_checker
// Port-level checks for the nearest-seek-first scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

module nssf_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        cfg_valid_i,
  input wire logic        cfg_ready_o,
  input wire logic [15:0] cfg_data_i,
  input wire logic        req_valid_i,
  input wire logic        req_ready_o,
  input wire logic [15:0] req_track_i,
  input wire logic        req_last_i,
  input wire logic        res_valid_o,
  input wire logic        res_ready_i,
  input wire logic [15:0] served_track_o,
  input wire logic [15:0] seek_distance_o,
  input wire logic [21:0] total_seek_o,
  input wire logic        last_served_o
);

  // stalled result holds valid, track, total and last flag
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_ready_i |=> res_valid_o && $stable(served_track_o)
      && $stable(total_seek_o) && $stable(last_served_o))
    else $error("result word changed while stalled");

  // running total always covers the current move
  a_total_cover: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> total_seek_o >= {6'd0, seek_distance_o})
    else $error("total seek below seek distance");

  // input closes only after a batch-closing word
  a_ready_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(req_ready_o) |-> $past(req_valid_i && req_last_i))
    else $error("request ready dropped without a last word");

  // mid-batch result means the batch is still in service
  a_mid_batch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !last_served_o |-> !req_ready_o)
    else $error("request input open during batch service");

endmodule

bind nearest_seek_first_scheduler_top nssf_checker u_nssf_checker (.*);

`default_nettype wire
